>>> hdl/i2c_hcrm_pkg.sv
// Package: codes, bit masks and transfer types of the two-wire host/client register block.
`default_nettype none

package i2c_hcrm_pkg;

    // Item kinds
    typedef enum logic [1:0] {
        CMD_REG_WR = 2'd0,
        CMD_REG_RD = 2'd1,
        CMD_WIRE   = 2'd2
    } t_cmd;

    // CPU register selection
    typedef enum logic [2:0] {
        SEL_HCTRLB  = 3'd0,
        SEL_HSTATUS = 3'd1,
        SEL_HADDR   = 3'd2,
        SEL_HDATA   = 3'd3,
        SEL_CCTRLB  = 3'd4,
        SEL_CSTATUS = 3'd5,
        SEL_CDATA   = 3'd6
    } t_sel;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_HCTRL  = 2'd0,
        CFG_CCTRL  = 2'd1,
        CFG_CADDR  = 2'd2,
        CFG_CAMASK = 2'd3
    } t_cfg_idx;

    // Host command field of a ctrlb write
    typedef enum logic [1:0] {
        HCMD_NONE  = 2'd0,
        HCMD_START = 2'd1,
        HCMD_READ  = 2'd2,
        HCMD_STOP  = 2'd3
    } t_hcmd;

    // Wire condition flags
    localparam logic [5:0] C_START = 6'h01;
    localparam logic [5:0] C_ADDR  = 6'h02;
    localparam logic [5:0] C_WRITE = 6'h04;
    localparam logic [5:0] C_READ  = 6'h08;
    localparam logic [5:0] C_ACK   = 6'h10;
    localparam logic [5:0] C_STOP  = 6'h20;

    // Host status bits
    localparam logic [7:0] HS_BUS    = 8'h03;
    localparam logic [7:0] HS_BUSERR = 8'h04;
    localparam logic [7:0] HS_ARB    = 8'h08;
    localparam logic [7:0] HS_RXACK  = 8'h10;
    localparam logic [7:0] HS_HOLD   = 8'h20;
    localparam logic [7:0] HS_WIF    = 8'h40;
    localparam logic [7:0] HS_RIF    = 8'h80;
    localparam logic [7:0] HS_OWNER  = 8'h02;
    localparam logic [7:0] HS_IDLE   = 8'h01;

    // Client status bits
    localparam logic [7:0] CS_AP   = 8'h01;
    localparam logic [7:0] CS_DIR  = 8'h02;
    localparam logic [7:0] CS_HOLD = 8'h20;
    localparam logic [7:0] CS_APIF = 8'h40;
    localparam logic [7:0] CS_DIF  = 8'h80;
    localparam logic [7:0] CS_W1C  = 8'hCC;

    // Most wire messages one item can cause
    localparam int MAX_MSG = 3;
    localparam int MSG_W   = $clog2(MAX_MSG + 1);

    // Result queue geometry
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    typedef struct packed {
        logic [1:0] cmd;
        logic [2:0] reg_select;
        logic [7:0] write_data;
        logic [5:0] wire_cond;
        logic [7:0] rx_addr;
        logic [7:0] wire_data;
        logic       peer_ack;
        logic       peer_data_valid;
        logic [7:0] peer_data;
    } t_in_item;

    typedef struct packed {
        logic [7:0] read_data;
        logic       wire_out_valid;
        logic [5:0] wire_out_cond;
        logic [7:0] wire_out_addr;
        logic [7:0] wire_out_data;
        logic       host_irq;
        logic       client_irq;
        logic       last;
    } t_out_item;

    // All results of one item, handed from the engine to the result queue
    typedef struct packed {
        logic [MSG_W-1:0]        count;
        t_out_item [MAX_MSG-1:0] items;
    } t_res_set;

endpackage

`default_nettype wire

>>> hdl/i2c_hcrm_engine.sv
// Engine: configuration, host and client state, and the per-item register/wire logic.
`default_nettype none

module i2c_hcrm_engine
    import i2c_hcrm_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [1:0] i_cfg_idx,
    input  wire logic [7:0] i_cfg_data,
    input  wire logic       i_fire,
    input  wire t_in_item   i_item,
    output t_res_set        o_res
);

    // Configuration
    logic [7:0] r_hctrl, r_cctrl, r_caddr, r_camask;

    // State
    logic [7:0] r_hs, r_haddr, r_hdata, r_cs, r_cdata, r_csaddr;
    logic [1:0] r_hbits;
    logic [5:0] r_clatch;
    logic       r_hreading, r_csel, r_hirq, r_cirq;

    logic [7:0] n_hs, n_haddr, n_hdata, n_cs, n_cdata, n_csaddr;
    logic [1:0] n_hbits;
    logic [5:0] n_clatch;
    logic       n_hreading, n_csel, n_hirq, n_cirq;

    logic [5:0]       m_cond [MAX_MSG];
    logic [7:0]       m_addr [MAX_MSG];
    logic [7:0]       m_data [MAX_MSG];
    logic [MSG_W-1:0] m_cnt;
    logic [7:0]       rd;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hctrl  <= '0;
            r_cctrl  <= '0;
            r_caddr  <= '0;
            r_camask <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_HCTRL:  r_hctrl  <= i_cfg_data;
                CFG_CCTRL:  r_cctrl  <= i_cfg_data;
                CFG_CADDR:  r_caddr  <= i_cfg_data;
                CFG_CAMASK: r_camask <= i_cfg_data;
                default:    r_hctrl  <= r_hctrl;
            endcase
        end
    end

    // Work out next state and messages of one item
    always_comb begin
        logic       en, do_start, do_read, ack, match;
        logic [7:0] v, st_a, ign;
        logic [6:0] diff;
        logic [5:0] cond;

        n_hs = r_hs; n_haddr = r_haddr; n_hdata = r_hdata; n_hbits = r_hbits;
        n_hreading = r_hreading; n_cs = r_cs; n_cdata = r_cdata;
        n_csaddr = r_csaddr; n_csel = r_csel; n_clatch = r_clatch;
        n_hirq = r_hirq; n_cirq = r_cirq;
        for (int k = 0; k < MAX_MSG; k++) begin
            m_cond[k] = '0;
            m_addr[k] = '0;
            m_data[k] = '0;
        end
        m_cnt    = '0;
        rd       = '0;
        en       = r_hctrl[0];
        v        = i_item.write_data;
        ack      = i_item.peer_ack;
        cond     = i_item.wire_cond;
        do_start = 1'b0;
        do_read  = 1'b0;
        st_a     = r_haddr;

        // Client address match under the mask
        ign   = r_camask[0] ? {1'b0, r_camask[7:1]} : 8'h00;
        diff  = (i_item.rx_addr[7:1] ^ r_caddr[7:1]) & ~ign[6:0];
        match = (diff == 7'd0);

        if (i_item.cmd == CMD_REG_WR) begin
            unique case (i_item.reg_select)
                SEL_HCTRLB: begin
                    n_hbits = v[3:2];
                    if (en) begin
                        if (v[3]) begin
                            // Flush: back to idle
                            n_hs   = (n_hs & ~(HS_BUS | HS_WIF | HS_RIF | HS_HOLD | HS_RXACK))
                                     | HS_IDLE;
                            n_hirq = 1'b0;
                        end else begin
                            unique case (v[1:0])
                                HCMD_START: begin
                                    do_start = 1'b1;
                                    st_a     = r_haddr;
                                end
                                HCMD_READ: begin
                                    if (r_hreading && !v[2]) begin
                                        n_hs    = n_hs & ~(HS_RIF | HS_HOLD);
                                        do_read = 1'b1;
                                    end
                                end
                                HCMD_STOP: begin
                                    m_cond[m_cnt] = C_STOP;
                                    m_addr[m_cnt] = r_haddr;
                                    m_data[m_cnt] = v[2] ? 8'h00 : 8'h01;
                                    m_cnt         = m_cnt + 1'b1;
                                    n_hs   = (n_hs & ~(HS_BUS | HS_WIF | HS_RIF | HS_HOLD))
                                             | HS_IDLE;
                                    n_hirq = 1'b0;
                                end
                                default: ;
                            endcase
                        end
                    end
                end
                SEL_HSTATUS: begin
                    n_hs = n_hs & ~(v & (HS_WIF | HS_RIF | HS_BUSERR | HS_ARB));
                    n_hs = (n_hs & ~HS_BUS) | (v & HS_BUS);
                    if ((n_hs & (HS_WIF | HS_RIF)) == 8'h00) n_hirq = 1'b0;
                end
                SEL_HADDR: begin
                    n_haddr = v;
                    if (en) begin
                        do_start = 1'b1;
                        st_a     = v;
                    end
                end
                SEL_HDATA: begin
                    n_hdata = v;
                    if (en && !r_hreading) begin
                        n_hs          = n_hs & ~(HS_WIF | HS_RXACK);
                        m_cond[m_cnt] = C_WRITE;
                        m_addr[m_cnt] = r_haddr;
                        m_data[m_cnt] = v;
                        m_cnt         = m_cnt + 1'b1;
                        if (!ack) n_hs = n_hs | HS_RXACK;
                        n_hs = n_hs | HS_WIF | HS_HOLD;
                        if (r_hctrl[6]) n_hirq = 1'b1;
                    end
                end
                SEL_CCTRLB: begin
                    n_clatch = v[7:2];
                    if (r_cctrl[0] && v[1]) begin
                        n_cs   = n_cs & ~(CS_DIF | CS_APIF | CS_HOLD);
                        n_cirq = 1'b0;
                    end
                end
                SEL_CSTATUS: begin
                    n_cs = n_cs & ~(v & CS_W1C);
                    if ((n_cs & (CS_APIF | CS_DIF)) == 8'h00) n_cirq = 1'b0;
                end
                SEL_CDATA: n_cdata = v;
                default: ;
            endcase
        end else if (i_item.cmd == CMD_REG_RD) begin
            unique case (i_item.reg_select)
                SEL_HCTRLB:  rd = {4'h0, r_hbits, 2'b00};
                SEL_HSTATUS: rd = r_hs;
                SEL_HADDR:   rd = r_haddr;
                SEL_HDATA: begin
                    // Reading data drops the read flag and the clock hold
                    n_hs = n_hs & ~(HS_RIF | HS_HOLD);
                    if ((n_hs & (HS_WIF | HS_RIF)) == 8'h00) n_hirq = 1'b0;
                    rd = r_hdata;
                end
                SEL_CCTRLB:  rd = {r_clatch, 2'b00};
                SEL_CSTATUS: rd = r_cs;
                SEL_CDATA:   rd = r_cdata;
                default:     rd = 8'h00;
            endcase
        end else if (i_item.cmd == CMD_WIRE && r_cctrl[0]) begin
            // Start: drop selection, then match the address byte
            if ((cond & C_START) != 6'd0) begin
                n_csel = 1'b0;
                if ((cond & C_ADDR) != 6'd0 && match) begin
                    n_csel   = 1'b1;
                    n_csaddr = i_item.rx_addr;
                    n_cs     = (n_cs & ~CS_DIR) | CS_AP | CS_APIF | CS_HOLD
                               | (i_item.rx_addr[0] ? CS_DIR : 8'h00);
                    m_cond[m_cnt] = C_ACK;
                    m_addr[m_cnt] = i_item.rx_addr;
                    m_data[m_cnt] = 8'h01;
                    m_cnt         = m_cnt + 1'b1;
                    if (r_cctrl[6]) n_cirq = 1'b1;
                end
            end
            // Data phase while selected
            if (n_csel) begin
                if ((cond & C_WRITE) != 6'd0) begin
                    n_cdata = i_item.wire_data;
                    n_cs    = (n_cs & ~CS_DIR) | CS_DIF | CS_HOLD;
                    m_cond[m_cnt] = C_ACK;
                    m_addr[m_cnt] = n_csaddr;
                    m_data[m_cnt] = 8'h01;
                    m_cnt         = m_cnt + 1'b1;
                    if (r_cctrl[7]) n_cirq = 1'b1;
                end
                if ((cond & C_READ) != 6'd0) begin
                    m_cond[m_cnt] = C_READ;
                    m_addr[m_cnt] = n_csaddr;
                    m_data[m_cnt] = n_cdata;
                    m_cnt         = m_cnt + 1'b1;
                    n_cs = n_cs | CS_DIR | CS_DIF | CS_HOLD;
                    if (r_cctrl[7]) n_cirq = 1'b1;
                end
            end
            // Stop: release selection
            if ((cond & C_STOP) != 6'd0) begin
                if (n_csel) begin
                    n_cs = (n_cs & ~(CS_AP | CS_HOLD)) | CS_APIF;
                    if (r_cctrl[6] || r_cctrl[5]) n_cirq = 1'b1;
                end
                n_csel   = 1'b0;
                n_csaddr = 8'h00;
            end
        end

        // Host start: address message, then either a read byte or the write flag
        if (do_start) begin
            n_hreading    = st_a[0];
            n_hs          = (n_hs & ~(HS_BUS | HS_WIF | HS_RIF | HS_ARB | HS_BUSERR | HS_RXACK))
                            | HS_OWNER;
            m_cond[m_cnt] = C_START | C_ADDR;
            m_addr[m_cnt] = st_a;
            m_data[m_cnt] = 8'h00;
            m_cnt         = m_cnt + 1'b1;
            if (!ack) n_hs = n_hs | HS_RXACK;
            if (st_a[0] && ack) begin
                do_read = 1'b1;
            end else begin
                n_hs = n_hs | HS_WIF | HS_HOLD;
                if (r_hctrl[6]) n_hirq = 1'b1;
            end
        end

        // Host read byte
        if (do_read) begin
            m_cond[m_cnt] = C_READ;
            m_addr[m_cnt] = n_haddr;
            m_data[m_cnt] = 8'h00;
            m_cnt         = m_cnt + 1'b1;
            if (i_item.peer_data_valid) n_hdata = i_item.peer_data;
            n_hs = n_hs | HS_RIF | HS_HOLD;
            if (r_hctrl[7]) n_hirq = 1'b1;
        end
    end

    // Pack the results of this item
    always_comb begin
        logic [MSG_W-1:0] n;
        n           = (m_cnt == '0) ? MSG_W'(1) : m_cnt;
        o_res.count = n;
        for (int k = 0; k < MAX_MSG; k++) begin
            o_res.items[k].read_data      = rd;
            o_res.items[k].wire_out_valid = (MSG_W'(k) < m_cnt);
            o_res.items[k].wire_out_cond  = m_cond[k];
            o_res.items[k].wire_out_addr  = m_addr[k];
            o_res.items[k].wire_out_data  = m_data[k];
            o_res.items[k].host_irq       = n_hirq;
            o_res.items[k].client_irq     = n_cirq;
            o_res.items[k].last           = (MSG_W'(k) == n - 1'b1);
        end
    end

    // Commit state when an item is processed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hs       <= '0;
            r_haddr    <= '0;
            r_hdata    <= '0;
            r_hbits    <= '0;
            r_hreading <= 1'b0;
            r_cs       <= '0;
            r_cdata    <= '0;
            r_csaddr   <= '0;
            r_csel     <= 1'b0;
            r_clatch   <= '0;
            r_hirq     <= 1'b0;
            r_cirq     <= 1'b0;
        end else if (i_fire) begin
            r_hs       <= n_hs;
            r_haddr    <= n_haddr;
            r_hdata    <= n_hdata;
            r_hbits    <= n_hbits;
            r_hreading <= n_hreading;
            r_cs       <= n_cs;
            r_cdata    <= n_cdata;
            r_csaddr   <= n_csaddr;
            r_csel     <= n_csel;
            r_clatch   <= n_clatch;
            r_hirq     <= n_hirq;
            r_cirq     <= n_cirq;
        end
    end

endmodule

`default_nettype wire

>>> hdl/i2c_hcrm_outq.sv
// Result queue: takes an item's one to three results at once; pops one a cycle while i_ready.
`default_nettype none

module i2c_hcrm_outq
    import i2c_hcrm_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_res_set i_res,
    output logic      o_room,
    output logic      o_valid,
    input  wire logic i_ready,
    output t_out_item o_item
);

    t_out_item        r_q [QDEPTH];
    logic [QAW-1:0]   r_wr, r_rd;
    logic [QAW:0]     r_cnt;
    logic             pop;

    // Room for a whole result set of one item
    assign o_room  = (r_cnt <= (QAW+1)'(QDEPTH - MAX_MSG));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_q[r_rd];
    assign pop     = o_valid && i_ready;

    // Store the results of an item
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            for (int k = 0; k < MAX_MSG; k++) begin
                if (MSG_W'(k) < i_res.count) r_q[r_wr + QAW'(k)] <= i_res.items[k];
            end
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + QAW'(i_res.count);
            if (pop)    r_rd <= r_rd + 1'b1;
            r_cnt <= r_cnt + (i_push ? (QAW+1)'(i_res.count) : '0)
                     - (pop ? (QAW+1)'(1) : '0);
        end
    end

endmodule

`default_nettype wire

>>> hdl/i2c_hcrm_top.sv
// Top level of the two-wire host/client register block: input register, engine, result queue.
//
//  channel  | handshake           | payload
//  ---------+---------------------+-----------------------------------------
//  input    | i_valid / o_ready   | i_in  (t_in_item: cpu access or wire msg)
//  result   | o_valid / i_ready   | o_out (t_out_item: read data, msg, irqs)
//  config   | i_cfg_we            | i_cfg_idx, i_cfg_data
//
//  An item taken at the input waits in the input register until the queue has room for all its
//  results; the engine then applies it and writes those results into the queue, which offers
//  the first of them. One item is taken per cycle while each gives one result and the result
//  port is ready; an item gives one result per wire message, or one if it has none, and they
//  leave in turn through the single read port of the queue. Reset is synchronous and clears all
//  control and state. A stalled result port fills the queue and then holds the input register.
`default_nettype none

module i2c_host_client_register_model_top
    import i2c_hcrm_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [1:0] i_cfg_idx,
    input  wire logic [7:0] i_cfg_data,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire t_in_item   i_in,
    output logic            o_valid,
    input  wire logic       i_ready,
    output t_out_item       o_out
);

    logic     r_in_vld;
    t_in_item r_in;
    logic     q_room, fire;
    t_res_set res;

    // Process the held item when the queue can take all its results
    assign fire    = r_in_vld && q_room;
    assign o_ready = !r_in_vld || fire;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_ready) begin
            r_in_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) r_in <= i_in;
    end

    i2c_hcrm_engine u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_fire     (fire),
        .i_item     (r_in),
        .o_res      (res)
    );

    i2c_hcrm_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fire),
        .i_res   (res),
        .o_room  (q_room),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_item  (o_out)
    );

endmodule

`default_nettype wire
